// ----- design/scpt_pkg.sv -----
`timescale 1ns / 1ps

package scpt_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int ID_W          = 8;
   localparam int POS_W         = 24;
   localparam int TIME_W        = POS_W + 1;

   localparam logic [POS_W-1:0] LENGTH_RESET = POS_W'(65536);

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TIME = 1'b1;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [POS_W-1:0] pos;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_SCAN,
      ST_INS_CHK,
      ST_ADD_OUT,
      ST_FULL_OUT,
      ST_T_SCAN,
      ST_T_CHK,
      ST_T_END,
      ST_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic ins_rd;
      logic ins_shift;
      logic ins_place;
      logic t_rd;
      logic fire;
      logic wrap;
      logic flush;
      logic push_add;
      logic add_full;
   } cmd_type;

   typedef struct packed {
      logic req_is_time;
      logic full;
      logic idx_zero;
      logic ins_gt;
      logic next_lt_count;
      logic pos_le_time;
      logic time_ge_len;
      logic wrap_stop;
      logic pend_valid;
      logic rsp_free;
   } status_type;

endpackage

// ----- design/scpt_req_if.sv -----
`timescale 1ns / 1ps

interface scpt_req_if;
   logic                           valid;
   logic                           ready;
   logic                           opcode;
   logic [scpt_pkg::ID_W-1:0]      cue_id;
   logic [scpt_pkg::POS_W-1:0]     cue_position;
   logic [scpt_pkg::TIME_W-1:0]    play_time;
   logic                           still_playing;

   modport source (output valid, output opcode, output cue_id, output cue_position,
                   output play_time, output still_playing, input ready);
   modport sink (input valid, input opcode, input cue_id, input cue_position,
                 input play_time, input still_playing, output ready);
endinterface

// ----- design/scpt_rsp_if.sv -----
`timescale 1ns / 1ps

interface scpt_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [scpt_pkg::ID_W-1:0]    fired_id;
   logic [scpt_pkg::POS_W-1:0]   fired_position;
   logic                         table_full;
   logic                         last;

   modport source (output valid, output fired_id, output fired_position,
                   output table_full, output last, input ready);
   modport sink (input valid, input fired_id, input fired_position,
                 input table_full, input last, output ready);
endinterface

// ----- design/scpt_ctrl.sv -----
`timescale 1ns / 1ps

module scpt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  scpt_pkg::status_type status,
   output scpt_pkg::cmd_type    cmd
);

   scpt_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         scpt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.req_is_time) begin
                  state_in = scpt_pkg::ST_T_SCAN;
               end else if (status.full) begin
                  state_in = scpt_pkg::ST_FULL_OUT;
               end else begin
                  state_in = scpt_pkg::ST_INS_SCAN;
               end
            end
         end
         scpt_pkg::ST_INS_SCAN: begin
            if (status.idx_zero) begin
               cmd.ins_place = 1'b1;
               state_in      = scpt_pkg::ST_ADD_OUT;
            end else begin
               cmd.ins_rd = 1'b1;
               state_in   = scpt_pkg::ST_INS_CHK;
            end
         end
         scpt_pkg::ST_INS_CHK: begin
            // move larger entries up one slot until the new one fits
            if (status.ins_gt) begin
               cmd.ins_shift = 1'b1;
               state_in      = scpt_pkg::ST_INS_SCAN;
            end else begin
               cmd.ins_place = 1'b1;
               state_in      = scpt_pkg::ST_ADD_OUT;
            end
         end
         scpt_pkg::ST_ADD_OUT: begin
            if (status.rsp_free) begin
               cmd.push_add = 1'b1;
               state_in     = scpt_pkg::ST_IDLE;
            end
         end
         scpt_pkg::ST_FULL_OUT: begin
            if (status.rsp_free) begin
               cmd.push_add = 1'b1;
               cmd.add_full = 1'b1;
               state_in     = scpt_pkg::ST_IDLE;
            end
         end
         scpt_pkg::ST_T_SCAN: begin
            if (status.next_lt_count) begin
               cmd.t_rd = 1'b1;
               state_in = scpt_pkg::ST_T_CHK;
            end else begin
               state_in = scpt_pkg::ST_T_END;
            end
         end
         scpt_pkg::ST_T_CHK: begin
            if (status.pos_le_time) begin
               // hold while the previous fired entry has nowhere to go
               if (!status.pend_valid || status.rsp_free) begin
                  cmd.fire = 1'b1;
                  state_in = scpt_pkg::ST_T_SCAN;
               end
            end else begin
               state_in = scpt_pkg::ST_T_END;
            end
         end
         scpt_pkg::ST_T_END: begin
            if (status.time_ge_len) begin
               cmd.wrap = 1'b1;
               state_in = status.wrap_stop ? scpt_pkg::ST_FLUSH : scpt_pkg::ST_T_SCAN;
            end else begin
               state_in = scpt_pkg::ST_FLUSH;
            end
         end
         scpt_pkg::ST_FLUSH: begin
            if (!status.pend_valid) begin
               state_in = scpt_pkg::ST_IDLE;
            end else if (status.rsp_free) begin
               cmd.flush = 1'b1;
               state_in  = scpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scpt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/scpt_datapath.sv -----
`timescale 1ns / 1ps

module scpt_datapath #(
   parameter int TABLE_DEPTH = scpt_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [scpt_pkg::POS_W-1:0]    csr_wr_data,
   input  logic                          req_opcode,
   input  logic [scpt_pkg::ID_W-1:0]     req_cue_id,
   input  logic [scpt_pkg::POS_W-1:0]    req_cue_position,
   input  logic [scpt_pkg::TIME_W-1:0]   req_play_time,
   input  logic                          req_still_playing,
   input  scpt_pkg::cmd_type             cmd,
   output scpt_pkg::status_type          status,
   scpt_rsp_if.source                    rsp
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef struct packed {
      logic [scpt_pkg::ID_W-1:0]  id;
      logic [scpt_pkg::POS_W-1:0] pos;
      logic                       full;
      logic                       last;
   } rsp_type;

   scpt_pkg::entry_type cue_table_ff [TABLE_DEPTH];

   logic [scpt_pkg::POS_W-1:0]  len_ff;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               next_ff, next_in;
   logic [scpt_pkg::ID_W-1:0]   id_ff;
   logic [scpt_pkg::POS_W-1:0]  pos_ff;
   logic [scpt_pkg::TIME_W-1:0] time_ff;
   logic                        playing_ff;
   logic [IW-1:0]               idx_ff;
   scpt_pkg::entry_type         rd_ff;
   scpt_pkg::entry_type         pend_ff;
   logic                        pend_valid_ff, pend_valid_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_ff, rsp_in;

   logic [scpt_pkg::POS_W-1:0]  len_eff;
   logic [scpt_pkg::TIME_W-1:0] len_ext;
   logic [scpt_pkg::POS_W-1:0]  pos_clamp;
   logic [scpt_pkg::TIME_W-1:0] time_lim;
   logic [scpt_pkg::TIME_W-1:0] time_clamp;
   logic [scpt_pkg::TIME_W-1:0] time_rem;
   logic                        rd_en;
   logic [IW-1:0]               rd_addr;
   logic                        wr_en;
   scpt_pkg::entry_type         wr_data;
   logic                        push;

   // a zero length behaves as one frame
   assign len_eff    = (len_ff == '0) ? scpt_pkg::POS_W'(1) : len_ff;
   assign len_ext    = {1'b0, len_eff};
   assign pos_clamp  = (req_cue_position > len_eff) ? len_eff : req_cue_position;
   assign time_lim   = {len_eff, 1'b0} - scpt_pkg::TIME_W'(1);
   assign time_clamp = (req_play_time > time_lim) ? time_lim : req_play_time;
   assign time_rem   = time_ff - len_ext;

   assign status.req_is_time   = (req_opcode == scpt_pkg::OP_TIME);
   assign status.full          = (count_ff == CW'(TABLE_DEPTH));
   assign status.idx_zero      = (idx_ff == '0);
   assign status.ins_gt        = (rd_ff.pos > pos_ff);
   assign status.next_lt_count = (next_ff < count_ff);
   assign status.pos_le_time   = ({1'b0, rd_ff.pos} <= time_ff);
   assign status.time_ge_len   = (time_ff >= len_ext);
   assign status.wrap_stop     = (time_rem == '0) && !playing_ff;
   assign status.pend_valid    = pend_valid_ff;
   assign status.rsp_free      = !rsp_valid_ff || rsp.ready;

   assign rd_en   = cmd.ins_rd || cmd.t_rd;
   assign rd_addr = cmd.t_rd ? next_ff[IW-1:0] : idx_ff - IW'(1);
   assign wr_en   = cmd.ins_shift || cmd.ins_place;
   assign wr_data = cmd.ins_shift ? rd_ff : scpt_pkg::entry_type'({id_ff, pos_ff});

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cue_table_ff[idx_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= cue_table_ff[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      next_in  = next_ff;
      if (cmd.ins_place) begin
         count_in = count_ff + CW'(1);
         // an entry landing at or before the cursor counts as already fired
         if ((count_ff != '0) && (CW'(idx_ff) <= next_ff)) begin
            next_in = next_ff + CW'(1);
         end
      end
      if (cmd.fire) begin
         next_in = next_ff + CW'(1);
      end
      if (cmd.wrap) begin
         next_in = '0;
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (cmd.fire) begin
         pend_valid_in = 1'b1;
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      push   = cmd.push_add || ((cmd.fire || cmd.flush) && pend_valid_ff);
      rsp_in = rsp_ff;
      if (cmd.push_add) begin
         rsp_in = '{id: '0, pos: '0, full: cmd.add_full, last: 1'b1};
      end else if (push) begin
         rsp_in = '{id: pend_ff.id, pos: pend_ff.pos, full: 1'b0, last: cmd.flush};
      end
      if (push) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= scpt_pkg::LENGTH_RESET;
         count_ff      <= '0;
         next_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            len_ff <= csr_wr_data;
         end
         count_ff      <= count_in;
         next_ff       <= next_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff      <= req_cue_id;
         pos_ff     <= pos_clamp;
         time_ff    <= time_clamp;
         playing_ff <= req_still_playing;
         idx_ff     <= count_ff[IW-1:0];
      end else if (cmd.ins_shift) begin
         idx_ff <= idx_ff - IW'(1);
      end else if (cmd.wrap) begin
         time_ff <= time_rem;
      end
      if (cmd.fire) begin
         pend_ff <= rd_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.fired_id       = rsp_ff.id;
   assign rsp.fired_position = rsp_ff.pos;
   assign rsp.table_full     = rsp_ff.full;
   assign rsp.last           = rsp_ff.last;

endmodule

// ----- design/sorted_cue_point_trigger.sv -----
`timescale 1ns / 1ps

// Keeps a position-sorted table of cue entries and fires them as playback time
// advances. Requests are taken one at a time: a new request is accepted only
// once the previous one has handed over all its responses to the response
// register. Every table step reads the single-port table memory through a
// registered read, so each entry examined passes through a read state and a
// check state. An add scans down from the top of the table, shifting each
// larger entry up one slot, and goes straight to its response when the
// table is full; a time request scans from the cursor, at most two passes over
// the table. The response side can stall any request. Every request closes
// with a response flagged last, except a time request that fires nothing, which
// gives no response.
module sorted_cue_point_trigger #(
   parameter int TABLE_DEPTH = scpt_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [scpt_pkg::POS_W-1:0] csr_wr_data,
   scpt_req_if.sink                   req_bus,
   scpt_rsp_if.source                 rsp_bus
);

   scpt_pkg::cmd_type    cmd;
   scpt_pkg::status_type status;
   logic                 req_ready;

   assign req_bus.ready = req_ready;

   scpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   scpt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_opcode        (req_bus.opcode),
      .req_cue_id        (req_bus.cue_id),
      .req_cue_position  (req_bus.cue_position),
      .req_play_time     (req_bus.play_time),
      .req_still_playing (req_bus.still_playing),
      .cmd               (cmd),
      .status            (status),
      .rsp               (rsp_bus)
   );

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while previous request still in progress");

   a_full_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.table_full) |-> (rsp_bus.last && rsp_bus.fired_id == '0))
      else $error("dropped add response malformed");

   a_fire_no_loss : assert property (@(posedge clock) disable iff (reset)
      cmd.fire |-> (!status.pend_valid || status.rsp_free))
      else $error("fired entry overwritten before delivery");

endmodule

// ----- sim/tb_sorted_cue_point_trigger.sv -----
`timescale 1ns / 1ps

module tb_sorted_cue_point_trigger;
   import scpt_pkg::*;

   localparam int DEPTH         = DEPTH_DEFAULT;
   localparam int SETTLE_CYCLES = 100;

   typedef struct packed {
      logic              op;
      logic [ID_W-1:0]   id;
      logic [POS_W-1:0]  pos;
      logic [TIME_W-1:0] t;
      logic              playing;
   } cue_request_t;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [POS_W-1:0] pos;
      logic             full;
      logic             last;
   } cue_result_t;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [POS_W-1:0] csr_wr_data;

   scpt_req_if req_bus ();
   scpt_rsp_if rsp_bus ();

   sorted_cue_point_trigger dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   // local copy of the cue table, its cursor and the sample length
   logic [ID_W-1:0]  shadow_id [DEPTH];
   logic [POS_W-1:0] shadow_pos [DEPTH];
   int               shadow_count;
   int               shadow_cursor;
   logic [POS_W-1:0] shadow_length;

   cue_result_t cue_results_due[$];
   int          mismatches;
   bit          calm;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic void trigger_outcome(input cue_request_t r);
      int unsigned      len;
      int unsigned      t;
      logic [POS_W-1:0] p;
      int               slot;
      int               j;
      int               pass;
      int               fired;
      len = (shadow_length == '0) ? 1 : int'(shadow_length);
      fired = 0;
      if (r.op == OP_ADD) begin
         p = (r.pos > len) ? POS_W'(len) : r.pos;
         if (shadow_count >= DEPTH) begin
            cue_results_due.push_back({8'h00, 24'h000000, 1'b1, 1'b1});
            return;
         end
         slot = 0;
         while (slot < shadow_count && shadow_pos[slot] <= p) slot++;
         // an entry landing at or before the cursor counts as already fired
         if (slot <= shadow_cursor && shadow_count != 0) shadow_cursor++;
         for (j = shadow_count; j > slot; j--) begin
            shadow_id[j]  = shadow_id[j-1];
            shadow_pos[j] = shadow_pos[j-1];
         end
         shadow_id[slot]  = r.id;
         shadow_pos[slot] = p;
         shadow_count++;
         cue_results_due.push_back({8'h00, 24'h000000, 1'b0, 1'b1});
         return;
      end
      t = r.t;
      if (t > 2 * len - 1) t = 2 * len - 1;
      for (pass = 0; pass < 2; pass++) begin
         while (shadow_cursor < shadow_count && shadow_pos[shadow_cursor] <= t) begin
            cue_results_due.push_back({shadow_id[shadow_cursor], shadow_pos[shadow_cursor],
                                       1'b0, 1'b0});
            shadow_cursor++;
            fired++;
         end
         if (t < len) break;
         // wrap past the end of the sample and restart from the first entry
         t = t - len;
         shadow_cursor = 0;
         if (t == 0 && !r.playing) break;
      end
      if (fired > 0) cue_results_due[cue_results_due.size()-1].last = 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("mismatch on %s at %0t: got %0h, want %0h", what, $realtime, got, want);
      mismatches++;
   endtask

   task automatic check_cue_result();
      cue_result_t want;
      if (cue_results_due.size() == 0) begin
         report_mismatch("response with no request pending", rsp_bus.fired_id, 0);
         return;
      end
      want = cue_results_due.pop_front();
      if (rsp_bus.fired_id !== want.id)
         report_mismatch("fired_id", rsp_bus.fired_id, want.id);
      if (rsp_bus.fired_position !== want.pos)
         report_mismatch("fired_position", rsp_bus.fired_position, want.pos);
      if (rsp_bus.table_full !== want.full)
         report_mismatch("table_full", rsp_bus.table_full, want.full);
      if (rsp_bus.last !== want.last)
         report_mismatch("last", rsp_bus.last, want.last);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) check_cue_result();
      rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 24);
   end

   task automatic send_request(input cue_request_t r);
      while (!calm && $urandom_range(0, 99) < 24) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= r.op;
      req_bus.cue_id        <= r.id;
      req_bus.cue_position  <= r.pos;
      req_bus.play_time     <= r.t;
      req_bus.still_playing <= r.playing;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      trigger_outcome(r);
   endtask

   // the fields a request does not use carry random bits
   task automatic add_cue(input logic [ID_W-1:0] id, input logic [POS_W-1:0] pos);
      send_request({OP_ADD, id, pos, TIME_W'($urandom), 1'($urandom)});
   endtask

   task automatic report_time(input logic [TIME_W-1:0] t, input logic playing);
      send_request({OP_TIME, ID_W'($urandom), POS_W'($urandom), t, playing});
   endtask

   // drop valid, drain every pending response, then let a silent time request finish
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (cue_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [POS_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      shadow_length = v;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [POS_W-1:0] pick_position();
      case ($urandom_range(0, 3))
         0: return POS_W'($urandom);
         1: return POS_W'($urandom_range(0, int'(shadow_length) + 2));
         2: return POS_W'($urandom_range(0, 3));
         default: return (shadow_count != 0) ?
                         shadow_pos[$urandom_range(0, shadow_count - 1)] : '0;
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] pick_time();
      int unsigned len;
      int unsigned base;
      len  = (shadow_length == '0) ? 1 : int'(shadow_length);
      base = (shadow_count != 0) ? shadow_pos[$urandom_range(0, shadow_count - 1)] : 0;
      case ($urandom_range(0, 5))
         0: return TIME_W'($urandom);
         1: return TIME_W'($urandom_range(0, 2 * len + 2));
         2: return TIME_W'(base + $urandom_range(0, 2) - 1);
         3: return TIME_W'(base + len);
         4: return TIME_W'(len);
         default: return TIME_W'(2 * len - $urandom_range(0, 1));
      endcase
   endfunction

   task automatic test_empty_table();
      // nothing stored yet: no responses, only the clamp and wrap at the reset length
      report_time('0, 1'b1);
      report_time({TIME_W{1'b1}}, 1'b0);
      settle();
   endtask

   task automatic test_sorted_insert();
      add_cue(8'hFF, {POS_W{1'b1}});
      add_cue(8'h00, '0);
      add_cue(8'h5A, POS_W'(500));
      add_cue(8'hA5, POS_W'(500));
      report_time(TIME_W'(500), 1'b1);
      report_time(TIME_W'(65536), 1'b1);
      report_time(TIME_W'(700), 1'b1);
      settle();
   endtask

   task automatic test_wrap_and_cursor();
      write_length(POS_W'(1000));
      add_cue(8'h33, POS_W'(800));
      // reaching the end with the source stopped halts at zero
      report_time(TIME_W'(1000), 1'b0);
      report_time(TIME_W'(1000), 1'b1);
      report_time({TIME_W{1'b1}}, 1'b1);
      add_cue(8'h77, '0);
      report_time(TIME_W'(1000), 1'b0);
      // cursor now at the start, so this one lands after it
      add_cue(8'h11, POS_W'(999));
      report_time(TIME_W'(999), 1'b0);
      settle();
   endtask

   task automatic test_table_full();
      while (shadow_count < DEPTH) add_cue(ID_W'($urandom), POS_W'($urandom_range(0, 1200)));
      add_cue(8'hC3, POS_W'(10));
      settle();
   endtask

   task automatic run_random_phase(input logic [POS_W-1:0] length, input int count,
                                   input bit quiet);
      write_length(length);
      calm = quiet;
      repeat (count) begin
         if ($urandom_range(0, 99) < 15) add_cue(ID_W'($urandom), pick_position());
         else report_time(pick_time(), 1'($urandom));
      end
      settle();
      calm = 1'b0;
   endtask

   task automatic test_random_lengths();
      run_random_phase(POS_W'(1000), 80, 1'b0);
      run_random_phase(POS_W'(1), 50, 1'b0);
      run_random_phase({POS_W{1'b1}}, 70, 1'b1);
      run_random_phase(POS_W'($urandom_range(2, 3000)), 70, 1'b0);
      run_random_phase(LENGTH_RESET, 60, 1'b0);
      run_random_phase(POS_W'($urandom_range(1, 16777215)), 70, 1'b0);
   endtask

   initial begin
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      req_bus.valid         = 1'b0;
      req_bus.opcode        = OP_ADD;
      req_bus.cue_id        = '0;
      req_bus.cue_position  = '0;
      req_bus.play_time     = '0;
      req_bus.still_playing = 1'b0;
      rsp_bus.ready         = 1'b0;
      shadow_count          = 0;
      shadow_cursor         = 0;
      shadow_length         = LENGTH_RESET;
      mismatches            = 0;
      calm                  = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_sorted_insert();
      test_wrap_and_cursor();
      test_table_full();
      test_random_lengths();
      settle();
      if (mismatches == 0 && cue_results_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
